@@ design/srmd_pkg.sv @@
// ----------------------------------------------------------------------------
// srmd_pkg: shared types and constants of the sensor ring mean direction block
// Holds the stage payload structs, the CORDIC arctangent table and the
// elaboration-time unit vector of each ring detector.
// ----------------------------------------------------------------------------
package srmd_pkg;

  localparam int SensorCountDef = 32;
  localparam int MaskWidth      = 32;
  localparam int CountWidth     = 6;
  localparam int SumWidth       = 23;
  localparam int VecWidth       = 32;
  localparam int AngWidth       = 22;
  localparam int DvdWidth       = 23;
  localparam int DirWidth       = 15;
  localparam int MagWidth       = 16;
  localparam int CordicSteps    = 16;
  localparam int CordicGain     = 39797;
  localparam int DegQ12         = 4096;
  localparam int HalfTurnQ12    = 180 * DegQ12;
  localparam int DirLimit       = 11520;
  localparam int MagMax         = 65535;

  // Running sums handed along the detector cells.
  typedef struct packed {
    logic [MaskWidth-1:0]       mask;
    logic [CountWidth-1:0]      count;
    logic signed [SumWidth-1:0] sx;
    logic signed [SumWidth-1:0] sy;
  } acc_t;

  // Vector under rotation in the CORDIC cells.
  typedef struct packed {
    logic signed [VecWidth-1:0] x;
    logic signed [VecWidth-1:0] y;
    logic signed [AngWidth-1:0] z;
    logic [CountWidth-1:0]      count;
  } vec_t;

  // Restoring division state, one quotient bit per cell.
  typedef struct packed {
    logic [DvdWidth-1:0]        dvd;
    logic [DvdWidth-1:0]        quot;
    logic [CountWidth-1:0]      rem;
    logic [CountWidth-1:0]      count;
    logic signed [DirWidth-1:0] dir;
  } div_t;

  typedef struct packed {
    logic signed [17:0] c;
    logic signed [17:0] s;
  } uv_t;

  // atan(2^-i) in Q12 degrees.
  function automatic int atan_q12(input int i);
    int r;
    case (i)
      0:       r = 184320;
      1:       r = 108810;
      2:       r = 57492;
      3:       r = 29184;
      4:       r = 14649;
      5:       r = 7331;
      6:       r = 3667;
      7:       r = 1833;
      8:       r = 917;
      9:       r = 458;
      10:      r = 229;
      11:      r = 115;
      12:      r = 57;
      13:      r = 29;
      14:      r = 14;
      default: r = 7;
    endcase
    return r;
  endfunction

  // Q16 cosine and sine of quad*90 + rem degrees, by CORDIC rotation.
  function automatic uv_t unit_vec(input int quad, input int rem);
    longint x, y, z, dx, dy, c, s;
    uv_t r;
    x = CordicGain;
    y = 0;
    z = longint'(rem) * DegQ12;
    if (rem == 0) begin
      x = 65536;
      y = 0;
    end else begin
      for (int i = 0; i < CordicSteps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - atan_q12(i);
        end else begin
          x = x + dx; y = y - dy; z = z + atan_q12(i);
        end
      end
    end
    case (quad)
      0:       begin c = x;  s = y;  end
      1:       begin c = -y; s = x;  end
      2:       begin c = -x; s = -y; end
      default: begin c = y;  s = -x; end
    endcase
    r.c = 18'(c);
    r.s = 18'(s);
    return r;
  endfunction

endpackage

@@ design/srmd_acc_cell.sv @@
// ----------------------------------------------------------------------------
// srmd_acc_cell: one ring detector
// Adds its fixed unit vector to the running sums and bumps the count when its mask bit is set.
// ----------------------------------------------------------------------------
module srmd_acc_cell #(
  parameter int BIT = 0,
  parameter int COS = 65536,
  parameter int SIN = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  srmd_pkg::acc_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output srmd_pkg::acc_t data_o
);

  logic           v_q;
  srmd_pkg::acc_t d_q, d_d;

  assign ready_o = ~v_q | ready_i;

  always_comb begin
    d_d = data_i;
    if (data_i.mask[BIT]) begin
      d_d.count = data_i.count + 1'b1;
      d_d.sx    = data_i.sx + srmd_pkg::SumWidth'(COS);
      d_d.sy    = data_i.sy + srmd_pkg::SumWidth'(SIN);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = d_q;

endmodule

@@ design/srmd_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// srmd_cordic_cell: one CORDIC vectoring step
// Turns the vector toward the x axis by atan(2^-STEP) and books the angle.
// ----------------------------------------------------------------------------
module srmd_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  srmd_pkg::vec_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output srmd_pkg::vec_t data_o
);

  localparam logic signed [srmd_pkg::AngWidth-1:0] Atan =
    srmd_pkg::AngWidth'(srmd_pkg::atan_q12(STEP));

  logic                                   v_q;
  srmd_pkg::vec_t                         d_q, d_d;
  logic signed [srmd_pkg::VecWidth-1:0]   dx, dy;

  assign ready_o = ~v_q | ready_i;
  assign dx = data_i.y >>> STEP;
  assign dy = data_i.x >>> STEP;

  always_comb begin
    d_d = data_i;
    if (data_i.y > 0) begin
      d_d.x = data_i.x + dx;
      d_d.y = data_i.y - dy;
      d_d.z = data_i.z + Atan;
    end else if (data_i.y < 0) begin
      d_d.x = data_i.x - dx;
      d_d.y = data_i.y + dy;
      d_d.z = data_i.z - Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = d_q;

endmodule

@@ design/srmd_div_cell.sv @@
// ----------------------------------------------------------------------------
// srmd_div_cell: one restoring division step
// Brings down dividend bit BIT and decides quotient bit BIT.
// ----------------------------------------------------------------------------
module srmd_div_cell #(
  parameter int BIT = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  srmd_pkg::div_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output srmd_pkg::div_t data_o
);

  logic                             v_q;
  srmd_pkg::div_t                   d_q, d_d;
  logic [srmd_pkg::CountWidth:0]    part;

  assign ready_o = ~v_q | ready_i;
  assign part    = {data_i.rem, data_i.dvd[BIT]};

  always_comb begin
    d_d = data_i;
    if (part >= {1'b0, data_i.count}) begin
      d_d.rem       = srmd_pkg::CountWidth'(part - {1'b0, data_i.count});
      d_d.quot[BIT] = 1'b1;
    end else begin
      d_d.rem = part[srmd_pkg::CountWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = d_q;

endmodule

@@ design/sensor_ring_mean_direction.sv @@
// ----------------------------------------------------------------------------
// sensor_ring_mean_direction: mean direction and length of a detector ring
// Each set detector bit adds a unit vector at its ring angle; the summed
// vector is turned into a direction (1/64 degree) and a mean length (Q0.16).
//
//   channel | dir | fields (lowest bit first)
//   --------+-----+------------------------------------------------------------
//   s_*     | in  | tdata[31:0] sensor_mask
//   m_*     | out | tdata[0] any_active, [6:1] active_count, [21:7] direction,
//           |     | [37:22] magnitude, [39:38] zero
//
// An item passes through LIM detector cells, where LIM is the smaller of
// SENSOR_COUNT and 32, then 16 CORDIC cells, one multiply stage,
// 23 divider cells and the output register.
// A new item can enter every cycle unless a stall has reached the input; every stage holds its own valid bit, so
// a stalled output only stops the stages behind it once they are full.
// Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module sensor_ring_mean_direction #(
  parameter int SENSOR_COUNT = srmd_pkg::SensorCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // sensor_mask
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o    // any_active, active_count, direction, magnitude
);

  localparam int Lim   = (SENSOR_COUNT < 32) ? SENSOR_COUNT : 32;
  localparam int Steps = srmd_pkg::CordicSteps;
  localparam int Dbits = srmd_pkg::DvdWidth;

  // Detector chain: each cell owns one detector's fixed unit vector.
  logic           a_v   [0:Lim];
  logic           a_rdy [0:Lim];
  srmd_pkg::acc_t a_d   [0:Lim];

  assign a_v[0]      = s_tvalid_i;
  assign s_tready_o  = a_rdy[0];
  assign a_d[0].mask = s_tdata_i;
  assign a_d[0].count = '0;
  assign a_d[0].sx    = '0;
  assign a_d[0].sy    = '0;

  for (genvar k = 0; k < Lim; k++) begin : g_acc
    localparam int Deg = (k * 360) / SENSOR_COUNT;
    localparam srmd_pkg::uv_t Uv = srmd_pkg::unit_vec(Deg / 90, Deg % 90);
    srmd_acc_cell #(
      .BIT (k),
      .COS (int'(Uv.c)),
      .SIN (int'(Uv.s))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (a_v[k]),
      .ready_o (a_rdy[k]),
      .data_i  (a_d[k]),
      .valid_o (a_v[k+1]),
      .ready_i (a_rdy[k+1]),
      .data_o  (a_d[k+1])
    );
  end

  // The sums are scaled by 256; a vector in the left half plane is first
  // turned by a half turn so the CORDIC cells only see x >= 0.
  logic           c_v   [0:Steps];
  logic           c_rdy [0:Steps];
  srmd_pkg::vec_t c_d   [0:Steps];
  logic signed [srmd_pkg::VecWidth-1:0] sx_sc, sy_sc;

  assign sx_sc = {a_d[Lim].sx[srmd_pkg::SumWidth-1], a_d[Lim].sx, 8'b0};
  assign sy_sc = {a_d[Lim].sy[srmd_pkg::SumWidth-1], a_d[Lim].sy, 8'b0};
  assign c_v[0]       = a_v[Lim];
  assign a_rdy[Lim]   = c_rdy[0];

  always_comb begin
    c_d[0].count = a_d[Lim].count;
    c_d[0].x     = sx_sc;
    c_d[0].y     = sy_sc;
    c_d[0].z     = '0;
    if (sx_sc < 0) begin
      c_d[0].x = -sx_sc;
      c_d[0].y = -sy_sc;
      c_d[0].z = (sy_sc >= 0) ? srmd_pkg::AngWidth'(srmd_pkg::HalfTurnQ12)
                              : -srmd_pkg::AngWidth'(srmd_pkg::HalfTurnQ12);
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_cordic
    srmd_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_v[i]),
      .ready_o (c_rdy[i]),
      .data_i  (c_d[i]),
      .valid_o (c_v[i+1]),
      .ready_i (c_rdy[i+1]),
      .data_o  (c_d[i+1])
    );
  end

  // Multiply stage: the length is scaled by the CORDIC gain, and since
  // floor(floor(a/2^24)/n) equals floor(a/(n*2^24)) only the top bits go on
  // to the divider. The direction is rounded to 1/64 degree and clamped here.
  logic           d_v   [0:Dbits];
  logic           d_rdy [0:Dbits];
  srmd_pkg::div_t d_d   [0:Dbits];

  logic                                 p_v_q;
  srmd_pkg::div_t                       p_q, p_d;
  logic [30:0]                          x_pos;
  logic [46:0]                          prod;
  logic signed [srmd_pkg::AngWidth-1:0] z_rnd;
  logic signed [16:0]                   dir_neg;

  assign c_rdy[Steps] = ~p_v_q | d_rdy[0];
  assign x_pos   = c_d[Steps].x[srmd_pkg::VecWidth-1] ? '0 : c_d[Steps].x[30:0];
  assign prod    = 47'(x_pos) * 47'(srmd_pkg::CordicGain);
  assign z_rnd   = c_d[Steps].z + srmd_pkg::AngWidth'(32);
  assign dir_neg = -17'(z_rnd >>> 6);

  always_comb begin
    p_d.dvd   = prod[46:24];
    p_d.quot  = '0;
    p_d.rem   = '0;
    p_d.count = c_d[Steps].count;
    if (dir_neg > 17'(srmd_pkg::DirLimit)) begin
      p_d.dir = srmd_pkg::DirWidth'(srmd_pkg::DirLimit);
    end else if (dir_neg < -17'(srmd_pkg::DirLimit)) begin
      p_d.dir = -srmd_pkg::DirWidth'(srmd_pkg::DirLimit);
    end else begin
      p_d.dir = dir_neg[srmd_pkg::DirWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (c_rdy[Steps]) begin
      p_v_q <= c_v[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_rdy[Steps] && c_v[Steps]) begin
      p_q <= p_d;
    end
  end

  assign d_v[0] = p_v_q;
  assign d_d[0] = p_q;

  // Divider chain: the quotient is formed from the top dividend bit down.
  for (genvar j = 0; j < Dbits; j++) begin : g_div
    srmd_div_cell #(
      .BIT (Dbits - 1 - j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (d_v[j]),
      .ready_o (d_rdy[j]),
      .data_i  (d_d[j]),
      .valid_o (d_v[j+1]),
      .ready_i (d_rdy[j+1]),
      .data_o  (d_d[j+1])
    );
  end

  // Output register: an empty ring gives zero length, a quotient beyond
  // the Q0.16 range saturates.
  logic        o_v_q;
  logic [39:0] o_q, o_d;
  logic [15:0] mag;
  logic        none;

  assign d_rdy[Dbits] = ~o_v_q | m_tready_i;
  assign none = (d_d[Dbits].count == '0);

  always_comb begin
    if (none) begin
      mag = '0;
    end else if (|d_d[Dbits].quot[Dbits-1:16]) begin
      mag = 16'(srmd_pkg::MagMax);
    end else begin
      mag = d_d[Dbits].quot[15:0];
    end
    o_d = {2'b00, mag, (none ? '0 : d_d[Dbits].dir), d_d[Dbits].count, ~none};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (d_rdy[Dbits]) begin
      o_v_q <= d_v[Dbits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_rdy[Dbits] && d_v[Dbits]) begin
      o_q <= o_d;
    end
  end

  assign m_tvalid_o = o_v_q;
  assign m_tdata_o  = o_q;

  // An empty ring reports neither a direction nor a length.
  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tdata_o[6:1] == 6'd0) |-> (m_tdata_o[37:7] == '0))
    else $error("empty ring gave nonzero direction or magnitude");

  // The activity flag agrees with the count.
  a_any_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tdata_o[0] == (m_tdata_o[6:1] != 6'd0)))
    else $error("any_active disagrees with active_count");

  // The direction stays within its clamp.
  a_dir_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> ($signed(m_tdata_o[21:7]) <= 15'sd11520 &&
                    $signed(m_tdata_o[21:7]) >= -15'sd11520))
    else $error("direction out of range");

  // No more than 32 detectors can be counted.
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tdata_o[6:1] <= 6'd32))
    else $error("active_count out of range");

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench of sensor_ring_mean_direction
// Drives detector masks with random gaps, predicts any_active, count,
// direction and mean length of each item, and compares every output item.
// ----------------------------------------------------------------------------
module testbench;

  localparam int Ring       = srmd_pkg::SensorCountDef;
  localparam int RandItems  = 1750;
  localparam int CycleLimit = 400000;
  localparam int Latency    = 32 + 41;

  typedef struct packed {
    logic [srmd_pkg::MagWidth-1:0]        mag;
    logic signed [srmd_pkg::DirWidth-1:0] dir;
    logic [srmd_pkg::CountWidth-1:0]      count;
    logic                                 any;
  } ring_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [31:0] s_tdata_i = '0;  // sensor_mask
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [39:0] m_tdata_o;       // any_active, active_count, direction, magnitude

  ring_result_t pending_results[$];
  int           failures = 0;
  int           cycles = 0;
  bit           sending_done = 1'b0;

  // Known-result rows: the expected value is typed in where the flag is set.
  typedef struct {
    logic [31:0]  mask;
    bit           fixed;
    ring_result_t result;
  } stim_row_t;

  // Cosines and sines of every detector angle, built by the bench's own CORDIC.
  longint det_cos[Ring];
  longint det_sin[Ring];

  sensor_ring_mean_direction #(.SENSOR_COUNT(Ring)) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Q12-degree arctangent steps used by both rotation and vectoring.
  function automatic longint atan_step(input int i);
    longint steps[16] = '{184320, 108810, 57492, 29184, 14649, 7331, 3667, 1833,
                          917, 458, 229, 115, 57, 29, 14, 7};
    return steps[i];
  endfunction

  // Fills the per-detector unit vectors (Q16) from whole-degree angles.
  function automatic void build_ring_vectors();
    longint x, y, z, dx, dy;
    int deg, quad, rest;
    for (int k = 0; k < Ring; k++) begin
      deg  = (k * 360 / Ring) % 360;
      quad = deg / 90;
      rest = deg % 90;
      x = srmd_pkg::CordicGain;
      y = 0;
      z = longint'(rest) * srmd_pkg::DegQ12;
      if (rest == 0) begin
        x = 65536;
      end else begin
        for (int i = 0; i < srmd_pkg::CordicSteps; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x -= dx; y += dy; z -= atan_step(i);
          end else begin
            x += dx; y -= dy; z += atan_step(i);
          end
        end
      end
      case (quad)
        0:       begin det_cos[k] = x;  det_sin[k] = y;  end
        1:       begin det_cos[k] = -y; det_sin[k] = x;  end
        2:       begin det_cos[k] = -x; det_sin[k] = -y; end
        default: begin det_cos[k] = y;  det_sin[k] = -x; end
      endcase
    end
  endfunction

  // Mean direction and length of the detectors set in one mask.
  function automatic ring_result_t mean_of_mask(input logic [31:0] mask);
    ring_result_t r;
    longint sx, sy, x, y, z, dx, dy, dir, mag;
    int cnt;
    sx = 0; sy = 0; cnt = 0; dir = 0; mag = 0;
    for (int k = 0; k < Ring && k < 32; k++) begin
      if (mask[k]) begin
        cnt++;
        sx += det_cos[k];
        sy += det_sin[k];
      end
    end
    if (cnt != 0 && (sx != 0 || sy != 0)) begin
      x = sx * 256;
      y = sy * 256;
      z = 0;
      // A vector in the left half-plane is turned by half a circle first.
      if (x < 0) begin
        z = (y >= 0) ? longint'(srmd_pkg::HalfTurnQ12) : -longint'(srmd_pkg::HalfTurnQ12);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < srmd_pkg::CordicSteps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += atan_step(i);
        end else if (y < 0) begin
          x -= dx; y += dy; z -= atan_step(i);
        end
      end
      dir = -((z + 32) >>> 6);
      if (dir > srmd_pkg::DirLimit) dir = srmd_pkg::DirLimit;
      if (dir < -srmd_pkg::DirLimit) dir = -srmd_pkg::DirLimit;
      if (x < 0) x = 0;
      mag = (x * srmd_pkg::CordicGain) / (longint'(cnt) << 24);
      if (mag > srmd_pkg::MagMax) mag = srmd_pkg::MagMax;
    end
    r.any   = (cnt != 0);
    r.count = srmd_pkg::CountWidth'(cnt);
    r.dir   = srmd_pkg::DirWidth'(dir);
    r.mag   = srmd_pkg::MagWidth'(mag);
    return r;
  endfunction

  // Gap of a few cycles mostly, now and then a long one, often none.
  function automatic int idle_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_mask(input logic [31:0] mask, input bit fixed,
                           input ring_result_t typed);
    int gap;
    gap = idle_gap();
    if (gap != 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= mask;
    pending_results.push_back(fixed ? typed : mean_of_mask(mask));
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  // Random masks: uniform words, sparse ones, dense ones, contiguous runs and single bits.
  function automatic logic [31:0] random_mask();
    logic [31:0] m;
    int len, at;
    case ($urandom_range(0, 4))
      0: m = $urandom();
      1: m = $urandom() & $urandom() & $urandom();
      2: m = $urandom() | $urandom() | $urandom();
      3: begin
        len = $urandom_range(1, 32);
        at  = $urandom_range(0, 31);
        m = (len == 32) ? 32'hFFFF_FFFF : ((32'd1 << len) - 1);
        m = (m << at) | (m >> (32 - at));
      end
      default: m = 32'd1 << $urandom_range(0, 31);
    endcase
    return m;
  endfunction

  // Output side: random stalls, field-by-field comparison against the queue.
  always @(posedge clk_i) begin
    ring_result_t got, want;
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) begin
        got = ring_result_t'(m_tdata_o[37:0]);
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected item %h", $time, m_tdata_o);
          failures++;
        end else begin
          want = pending_results.pop_front();
          if (got.any !== want.any)
            $display("%0t: any_active expected %0d got %0d", $time, want.any, got.any);
          if (got.count !== want.count)
            $display("%0t: active_count expected %0d got %0d", $time, want.count,
                     got.count);
          if (got.dir !== want.dir)
            $display("%0t: direction expected %0d got %0d", $time, want.dir, got.dir);
          if (got.mag !== want.mag)
            $display("%0t: magnitude expected %0d got %0d", $time, want.mag, got.mag);
          if (got !== want || m_tdata_o[39:38] !== 2'b00) failures++;
        end
      end
      // Stretches of full readiness alternate with random stalls.
      if (sending_done || cycles % 400 < 100) m_tready_i <= 1'b1;
      else m_tready_i <= (idle_gap() == 0);
    end
  end

  initial begin
    stim_row_t    rows[$];
    ring_result_t none, single;
    int           wait_cycles;
    none   = '0;
    // A lone detector at angle zero is never rotated, so its length keeps
    // the bare CORDIC gain.
    single = '{mag: 16'd39797, dir: '0, count: 6'd1, any: 1'b1};
    build_ring_vectors();
    // No detector set, a lone detector at angle zero, then full and patterned rings.
    rows.push_back('{32'h0000_0000, 1'b1, none});
    rows.push_back('{32'h0000_0001, 1'b1, single});
    rows.push_back('{32'hFFFF_FFFF, 1'b0, none});
    rows.push_back('{32'h0001_0001, 1'b0, none});
    rows.push_back('{32'h5555_5555, 1'b0, none});
    rows.push_back('{32'hAAAA_AAAA, 1'b0, none});
    rows.push_back('{32'h8000_0000, 1'b0, none});
    rows.push_back('{32'h0000_0100, 1'b0, none});
    rows.push_back('{32'h0001_0000, 1'b0, none});
    rows.push_back('{32'h0100_0000, 1'b0, none});
    rows.push_back('{32'h0101_0101, 1'b0, none});
    rows.push_back('{32'h0000_0003, 1'b0, none});
    rows.push_back('{32'h0001_8000, 1'b0, none});
    rows.push_back('{32'hC000_0001, 1'b0, none});
    rows.push_back('{32'h7FFF_FFFF, 1'b0, none});
    rows.push_back('{32'hFFFE_FFFF, 1'b0, none});
    rows.push_back('{32'h0000_FFFF, 1'b0, none});
    rows.push_back('{32'hFFFF_0000, 1'b0, none});
    rows.push_back('{32'h0001_0101, 1'b0, none});
    rows.push_back('{32'h0080_0080, 1'b0, none});
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_mask(rows[i].mask, rows[i].fixed, rows[i].result);
    for (int n = 0; n < RandItems; n++) send_mask(random_mask(), 1'b0, none);
    s_tvalid_i   <= 1'b0;
    sending_done <= 1'b1;
    while (pending_results.size() != 0) @(posedge clk_i);
    wait_cycles = 0;
    while (wait_cycles < 2 * Latency) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    if (failures == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
